// ===== hw/rtl/d2s_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2s_pkg
// Shared types and constants for the depth-to-space address generator.
// ----------------------------------------------------------------------------
package d2s_pkg;

  // Offset arithmetic wraps modulo 2^OffsetBits, then fits the 32-bit field.
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned OffW       = 32;
  localparam logic [OffW-1:0] OffsetMask =
      (OffsetBits >= OffW) ? {OffW{1'b1}} : OffW'((64'd1 << OffsetBits) - 64'd1);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBlockSize   = 3'd0,
    CfgChannelsOut = 3'd1,
    CfgInHeight    = 3'd2,
    CfgInWidth     = 3'd3,
    CfgBatchCount  = 3'd4,
    CfgMode        = 3'd5,
    CfgElemBytes   = 3'd6
  } d2s_cfg_e;

  // Channel mapping.
  localparam logic ModeDcr = 1'b0;
  localparam logic ModeCrd = 1'b1;

  // Steps of the multiply-accumulate sequence that builds both offsets.
  typedef enum logic [2:0] {
    StepLoad  = 3'd0,
    StepMac1  = 3'd1,
    StepMac2  = 3'd2,
    StepMac3  = 3'd3,
    StepMac4  = 3'd4,
    StepMac5  = 3'd5,
    StepScale = 3'd6
  } d2s_step_e;

  // Controller to datapath.
  typedef struct packed {
    logic      clear_pos;  // restart: return the walk to element zero
    logic      mac;        // run one accumulate step
    d2s_step_e step;       // which step
    logic      load_out;   // move the offsets to the output register and advance
  } d2s_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_busy;        // output register holds a result that is not taken now
  } d2s_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/d2s_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2s_in_if
// Request channel: one transaction asks for the next address pair.
// ----------------------------------------------------------------------------
interface d2s_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/d2s_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2s_out_if
// Result channel: source and destination byte offsets and the last flag.
// ----------------------------------------------------------------------------
interface d2s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_offset;
  logic [31:0] dst_offset;
  logic        last;

  modport source (output valid, output src_offset, output dst_offset, output last,
                  input ready);
  modport sink   (input valid, input src_offset, input dst_offset, input last,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/d2s_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2s_ctrl
// Sequencer: accepts a request, steps the datapath through the offset
// calculation and hands the result to the output register.
// ----------------------------------------------------------------------------
module d2s_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_restart_i,
  output logic                 in_ready_o,
  input  d2s_pkg::d2s_status_t st_i,
  output d2s_pkg::d2s_cmd_t    cmd_o
);
  import d2s_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StDone
  } state_e;

  state_e    state_q, state_d;
  d2s_step_e step_q, step_d;
  logic      in_acc;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    cmd_o.clear_pos = 1'b0;
    cmd_o.mac       = 1'b0;
    cmd_o.step      = step_q;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_o.clear_pos = in_restart_i;
          step_d          = StepLoad;
          state_d         = StCalc;
        end
      end
      StCalc: begin
        cmd_o.mac = 1'b1;
        if (step_q == StepScale) begin
          state_d = StDone;
        end else begin
          step_d = d2s_step_e'(step_q + 3'd1);
        end
      end
      StDone: begin
        if (!st_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= StepLoad;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StCalc) && (step_q == StepLoad))
    else $error("accepted request did not start the calculation at its first step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !st_i.out_busy)
    else $error("output register loaded while it still holds a result");

  a_calc_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCalc) && (step_q == StepScale) |=> (state_q == StDone))
    else $error("calculation did not finish after its scaling step");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/d2s_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2s_dpath
// Configuration registers, walk position counters, two multiply-accumulate
// lanes for the source and destination offsets, and the output register.
// ----------------------------------------------------------------------------
module d2s_dpath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [d2s_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [d2s_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  d2s_pkg::d2s_cmd_t             cmd_i,
  output d2s_pkg::d2s_status_t          st_o,
  input  wire                           out_ready_i,
  output logic                          out_valid_o,
  output logic [d2s_pkg::OffW-1:0]      src_offset_o,
  output logic [d2s_pkg::OffW-1:0]      dst_offset_o,
  output logic                          last_o
);
  import d2s_pkg::*;

  // Saturate a register value into 1..hi.
  function automatic logic [12:0] clamp13(input logic [12:0] v, input logic [12:0] hi);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [4:0]  block_size_q;
  logic [12:0] channels_out_q, in_height_q, in_width_q;
  logic [8:0]  batch_count_q;
  logic        mode_q;
  logic [3:0]  elem_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q   <= 5'd2;
      channels_out_q <= 13'd1;
      in_height_q    <= 13'd1;
      in_width_q     <= 13'd1;
      batch_count_q  <= 9'd1;
      mode_q         <= ModeDcr;
      elem_bytes_q   <= 4'd1;
    end else if (cfg_we_i) begin
      case (d2s_cfg_e'(cfg_index_i))
        CfgBlockSize:   block_size_q   <= cfg_wdata_i[4:0];
        CfgChannelsOut: channels_out_q <= cfg_wdata_i;
        CfgInHeight:    in_height_q    <= cfg_wdata_i;
        CfgInWidth:     in_width_q     <= cfg_wdata_i;
        CfgBatchCount:  batch_count_q  <= cfg_wdata_i[8:0];
        CfgMode:        mode_q         <= cfg_wdata_i[0];
        CfgElemBytes:   elem_bytes_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective limits.
  logic [4:0]  bs_c;
  logic [12:0] nc_c, nh_c, nw_c;
  logic [8:0]  nb_c;
  logic [3:0]  eb_c;

  assign bs_c = 5'(clamp13({8'd0, block_size_q}, 13'd16));
  assign nc_c = clamp13(channels_out_q, 13'd4096);
  assign nh_c = clamp13(in_height_q, 13'd4096);
  assign nw_c = clamp13(in_width_q, 13'd4096);
  assign nb_c = 9'(clamp13({4'd0, batch_count_q}, 13'd256));
  assign eb_c = 4'(clamp13({9'd0, elem_bytes_q}, 13'd8));

  // Walk position.
  logic [7:0]  batch_q, batch_d;
  logic [11:0] chan_q, chan_d, src_row_q, src_row_d, src_col_q, src_col_d;
  logic [3:0]  blk_row_q, blk_row_d, blk_col_q, blk_col_d;
  logic        w_bc, w_sc, w_br, w_sr, w_ch, w_ba, last_c;

  assign w_bc = ({1'b0, blk_col_q} + 5'd1)  >= bs_c;
  assign w_sc = ({1'b0, src_col_q} + 13'd1) >= nw_c;
  assign w_br = ({1'b0, blk_row_q} + 5'd1)  >= bs_c;
  assign w_sr = ({1'b0, src_row_q} + 13'd1) >= nh_c;
  assign w_ch = ({1'b0, chan_q} + 13'd1)    >= nc_c;
  assign w_ba = ({1'b0, batch_q} + 9'd1)    >= nb_c;
  assign last_c = w_bc && w_sc && w_br && w_sr && w_ch && w_ba;

  always_comb begin
    batch_d   = batch_q;
    chan_d    = chan_q;
    src_row_d = src_row_q;
    blk_row_d = blk_row_q;
    src_col_d = src_col_q;
    blk_col_d = blk_col_q;
    if (cmd_i.clear_pos) begin
      batch_d   = '0;
      chan_d    = '0;
      src_row_d = '0;
      blk_row_d = '0;
      src_col_d = '0;
      blk_col_d = '0;
    end else if (cmd_i.load_out) begin
      // Odometer: each level moves on when every level below it wraps.
      blk_col_d = w_bc ? 4'd0 : blk_col_q + 4'd1;
      if (w_bc) begin
        src_col_d = w_sc ? 12'd0 : src_col_q + 12'd1;
      end
      if (w_bc && w_sc) begin
        blk_row_d = w_br ? 4'd0 : blk_row_q + 4'd1;
      end
      if (w_bc && w_sc && w_br) begin
        src_row_d = w_sr ? 12'd0 : src_row_q + 12'd1;
      end
      if (w_bc && w_sc && w_br && w_sr) begin
        chan_d = w_ch ? 12'd0 : chan_q + 12'd1;
      end
      if (w_bc && w_sc && w_br && w_sr && w_ch) begin
        batch_d = w_ba ? 8'd0 : batch_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q   <= '0;
      chan_q    <= '0;
      src_row_q <= '0;
      blk_row_q <= '0;
      src_col_q <= '0;
      blk_col_q <= '0;
    end else begin
      batch_q   <= batch_d;
      chan_q    <= chan_d;
      src_row_q <= src_row_d;
      blk_row_q <= blk_row_d;
      src_col_q <= src_col_d;
      blk_col_q <= blk_col_d;
    end
  end

  // Multiply-accumulate lanes: acc = acc * mul + add, all modulo 2^32.
  logic [12:0]     src_mul, dst_mul;
  logic [11:0]     src_add, dst_add;
  logic [OffW-1:0] src_acc_q, src_acc_d, dst_acc_q, dst_acc_d;

  always_comb begin
    src_mul = 13'd0;
    src_add = 12'd0;
    dst_mul = 13'd0;
    dst_add = 12'd0;
    case (cmd_i.step)
      StepLoad: begin
        src_add = {4'd0, batch_q};
        dst_add = {4'd0, batch_q};
      end
      StepMac1: begin
        src_mul = (mode_q == ModeCrd) ? nc_c : 13'(bs_c);
        src_add = (mode_q == ModeCrd) ? chan_q : 12'(blk_row_q);
        dst_mul = nc_c;
        dst_add = chan_q;
      end
      StepMac2: begin
        src_mul = 13'(bs_c);
        src_add = (mode_q == ModeCrd) ? 12'(blk_row_q) : 12'(blk_col_q);
        dst_mul = nh_c;
        dst_add = src_row_q;
      end
      StepMac3: begin
        src_mul = (mode_q == ModeCrd) ? 13'(bs_c) : nc_c;
        src_add = (mode_q == ModeCrd) ? 12'(blk_col_q) : chan_q;
        dst_mul = 13'(bs_c);
        dst_add = 12'(blk_row_q);
      end
      StepMac4: begin
        src_mul = nh_c;
        src_add = src_row_q;
        dst_mul = nw_c;
        dst_add = src_col_q;
      end
      StepMac5: begin
        src_mul = nw_c;
        src_add = src_col_q;
        dst_mul = 13'(bs_c);
        dst_add = 12'(blk_col_q);
      end
      StepScale: begin
        src_mul = 13'(eb_c);
        dst_mul = 13'(eb_c);
      end
      default: ;
    endcase
  end

  assign src_acc_d = src_acc_q * OffW'(src_mul) + OffW'(src_add);
  assign dst_acc_d = dst_acc_q * OffW'(dst_mul) + OffW'(dst_add);

  // The accumulators start from zero so that the load step, which multiplies
  // the old value by zero, never sees an unknown value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_acc_q <= '0;
      dst_acc_q <= '0;
    end else if (cmd_i.mac) begin
      src_acc_q <= src_acc_d;
      dst_acc_q <= dst_acc_d;
    end
  end

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic [OffW-1:0] out_src_q, out_dst_q;
  logic            out_last_q;

  assign out_valid_d = cmd_i.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_src_q  <= src_acc_q & OffsetMask;
      out_dst_q  <= dst_acc_q & OffsetMask;
      out_last_q <= last_c;
    end
  end

  assign st_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign src_offset_o  = out_src_q;
  assign dst_offset_o  = out_dst_q;
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_pos |=> (batch_q == '0) && (chan_q == '0) && (src_row_q == '0) &&
                        (blk_row_q == '0) && (src_col_q == '0) && (blk_col_q == '0))
    else $error("restart did not return the walk to element zero");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && last_c |=> (batch_q == '0) && (chan_q == '0) &&
                                 (src_row_q == '0) && (blk_row_q == '0) &&
                                 (src_col_q == '0) && (blk_col_q == '0))
    else $error("walk did not wrap after the final element");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q && (out_last_q == $past(last_c)))
    else $error("loaded result not presented with its last flag");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/depth_to_space_address_gen_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_to_space_address_gen_top
// Depth-to-space address generator: for each request, the source and
// destination byte offsets of the next output element of an NCHW tensor.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                           Handshake
//   in_i      sink       restart                           valid / ready
//   out_o     source     src_offset, dst_offset, last      valid / ready
//   cfg       write      cfg_index_i, cfg_wdata_i          cfg_we_i only
//
// A request is taken when the block is idle. Both offset lanes then run
// the seven-step multiply-accumulate sequence in step, after which the
// result is captured and the block returns to idle for the next request.
// The result sits in an output register, so a new request is taken while
// the previous result waits; the following result is held back until the
// output register is free.
// Reset is asynchronous and active low and returns the walk and the
// configuration to their defaults; no clearing pass is needed.
//
module depth_to_space_address_gen_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [d2s_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [d2s_pkg::CfgDataW-1:0]  cfg_wdata_i,
  d2s_in_if.sink                       in_i,
  d2s_out_if.source                    out_o
);
  import d2s_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  d2s_cmd_t    cmd;
  d2s_status_t st;
  logic        in_ready;

  // The sequencer owns the request handshake and decides when each
  // accumulate step runs and when the result may enter the output register.
  d2s_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_ready),
    .st_i         (st),
    .cmd_o        (cmd)
  );

  assign in_i.ready = in_ready;

  // The datapath holds the configuration, the walk position, the two
  // accumulators and the output register with its valid flag.
  d2s_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .src_offset_o (out_o.src_offset),
    .dst_offset_o (out_o.dst_offset),
    .last_o       (out_o.last)
  );

endmodule
`default_nettype wire

// ===== tb/tb_depth_to_space_address_gen_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_to_space_address_gen_top
// Self-checking regression for the depth-to-space address generator. An
// independent model of the output walk predicts the source offset,
// destination offset and last flag of every request. A single monitor
// compares each returned transaction with the oldest prediction. Directed
// tests cover the register extremes, saturation, offset wrap-around,
// registers changed mid-walk and one long receiver hold-off. Random
// phases follow, under several handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_depth_to_space_address_gen_top;
  import d2s_pkg::*;

  // Clock period is 4 ns. The run is abandoned after this many cycles.
  localparam int unsigned CycleLimit   = 400000;
  // After the last result we allow a comfortable margin before touching
  // the registers again.
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned MaxGap       = 20;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandomPhases = 44;

  // One predicted or observed result transaction.
  typedef struct packed {
    logic [OffW-1:0] src;
    logic [OffW-1:0] dst;
    logic            last;
  } addr_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // The receiver's ready is produced by its own process below.
  logic sink_ready = 1'b0;
  logic hold_on    = 1'b0;
  event hold_start;

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          fail_count    = 0;
  int unsigned cycle_count   = 0;

  d2s_in_if  in_ch ();
  d2s_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  depth_to_space_address_gen_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers, held at their raw
  // widths so that out-of-range writes are saturated exactly as the block
  // does it, and the current position of the output walk.
  // --------------------------------------------------------------------------
  logic [4:0]  reg_block   = 5'd2;
  logic [12:0] reg_chans   = 13'd1;
  logic [12:0] reg_height  = 13'd1;
  logic [12:0] reg_width   = 13'd1;
  logic [8:0]  reg_batches = 9'd1;
  logic        reg_mode    = ModeDcr;
  logic [3:0]  reg_ebytes  = 4'd1;

  logic [7:0]  pos_batch = '0;
  logic [11:0] pos_chan  = '0;
  logic [11:0] pos_row   = '0;
  logic [3:0]  pos_brow  = '0;
  logic [11:0] pos_col   = '0;
  logic [3:0]  pos_bcol  = '0;

  // Values of the registers for the next configuration pass.
  logic [CfgDataW-1:0] reg_plan [7];

  // Expected result transactions, oldest first.
  addr_pair_t pending_pairs [$];

  // A zero register acts as one and a value above the maximum as the maximum.
  function automatic longint unsigned saturate(input longint unsigned v,
                                               input longint unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Works out the offsets of the element at the current position and then
  // advances the walk. The counters are handled innermost first: block
  // column, source column, block row, source row, channel, batch.
  function automatic addr_pair_t walk_next_element(input logic restart_walk);
    longint unsigned bs, nc, nh, nw, nb, eb, cin, src_el, dst_el;
    longint unsigned pos [6];
    longint unsigned lim [6];
    logic            carry;
    addr_pair_t      pair;

    bs = saturate(reg_block, 16);
    nc = saturate(reg_chans, 4096);
    nh = saturate(reg_height, 4096);
    nw = saturate(reg_width, 4096);
    nb = saturate(reg_batches, 256);
    eb = saturate(reg_ebytes, 8);

    if (restart_walk) begin
      pos_batch = '0;
      pos_chan  = '0;
      pos_row   = '0;
      pos_brow  = '0;
      pos_col   = '0;
      pos_bcol  = '0;
    end

    pos = '{pos_bcol, pos_col, pos_brow, pos_row, pos_chan, pos_batch};
    lim = '{bs, nw, bs, nh, nc, nb};

    if (reg_mode == ModeCrd) begin
      cin = pos[4] * bs * bs + pos[2] * bs + pos[0];
    end else begin
      cin = (pos[2] * bs + pos[0]) * nc + pos[4];
    end

    src_el = ((pos[5] * nc * bs * bs + cin) * nh + pos[3]) * nw + pos[1];
    dst_el = ((pos[5] * nc + pos[4]) * nh * bs + pos[3] * bs + pos[2]) * nw * bs
             + pos[1] * bs + pos[0];

    // A counter at or past its limit counts as being at its end.
    pair.last = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (pos[i] + 1 < lim[i]) pair.last = 1'b0;
    end
    pair.src = OffW'(src_el * eb) & OffsetMask;
    pair.dst = OffW'(dst_el * eb) & OffsetMask;

    carry = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (carry) begin
        if (pos[i] + 1 >= lim[i]) begin
          pos[i] = 0;
        end else begin
          pos[i] = pos[i] + 1;
          carry  = 1'b0;
        end
      end
    end

    pos_bcol  = 4'(pos[0]);
    pos_col   = 12'(pos[1]);
    pos_brow  = 4'(pos[2]);
    pos_row   = 12'(pos[3]);
    pos_chan  = 12'(pos[4]);
    pos_batch = 8'(pos[5]);
    return pair;
  endfunction

  function automatic void record_reg(input d2s_cfg_e idx, input logic [CfgDataW-1:0] v);
    case (idx)
      CfgBlockSize:   reg_block   = v[4:0];
      CfgChannelsOut: reg_chans   = v[12:0];
      CfgInHeight:    reg_height  = v[12:0];
      CfgInWidth:     reg_width   = v[12:0];
      CfgBatchCount:  reg_batches = v[8:0];
      CfgMode:        reg_mode    = v[0];
      CfgElemBytes:   reg_ebytes  = v[3:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. Results are checked before the request of the same edge is
  // predicted, so a result can never be matched against its own request.
  // Both handshakes are sampled at the rising edge, before any of the
  // nonblocking updates of that edge have taken effect.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    addr_pair_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pairs.size() == 0) begin
          $error("result transaction with no request outstanding: src %h dst %h last %b",
                 out_ch.src_offset, out_ch.dst_offset, out_ch.last);
          fail_count++;
        end else begin
          want = pending_pairs.pop_front();
          if (out_ch.src_offset !== want.src) begin
            $error("src_offset: expected %h, got %h", want.src, out_ch.src_offset);
            fail_count++;
          end
          if (out_ch.dst_offset !== want.dst) begin
            $error("dst_offset: expected %h, got %h", want.dst, out_ch.dst_offset);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_ch.last);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_pairs.push_back(walk_next_element(in_ch.restart));
      end
    end
  end

  // The receiver stalls at random, or all the time while a hold-off runs.
  always @(posedge clk_i) begin
    if (!rst_ni || hold_on) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // A long hold-off of the receiver, counted here so that the sender can
  // keep offering transactions in the meantime and the block backs up.
  always begin
    @(hold_start);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("depth_to_space_address_gen_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks. Every task is entered and left just after a rising edge.
  // --------------------------------------------------------------------------

  // Offers one request, after a random gap, and returns once it is taken.
  // Valid is left high so that back-to-back requests follow without a gap.
  task automatic offer_request(input logic restart_walk);
    int unsigned gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      gap++;
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart_walk;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drops valid and waits until every predicted result has come back, then
  // lets the block settle so that a register write finds it idle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Writes the selected registers from reg_plan, one per cycle.
  task automatic apply_plan(input bit [6:0] sel);
    for (int i = 0; i < 7; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= CfgIdxW'(i);
        cfg_wdata <= reg_plan[i];
        record_reg(d2s_cfg_e'(i), reg_plan[i]);
        @(posedge clk_i);
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all_regs(input logic [CfgDataW-1:0] bsz, chans, height, width,
                              batches, map_mode, ebytes);
    reg_plan[CfgBlockSize]   = bsz;
    reg_plan[CfgChannelsOut] = chans;
    reg_plan[CfgInHeight]    = height;
    reg_plan[CfgInWidth]     = width;
    reg_plan[CfgBatchCount]  = batches;
    reg_plan[CfgMode]        = map_mode;
    reg_plan[CfgElemBytes]   = ebytes;
    apply_plan(7'h7F);
  endtask

  // Mostly small shapes so that walks complete often; now and then the
  // maximum, zero, or a value beyond the maximum that must saturate.
  function automatic logic [CfgDataW-1:0] pick_value(input d2s_cfg_e idx);
    int unsigned roll, top, field_max, modest;
    roll = $urandom_range(99);
    case (idx)
      CfgBlockSize:   begin top = 16;   field_max = 31;   modest = 3; end
      CfgChannelsOut: begin top = 4096; field_max = 8191; modest = 2; end
      CfgInHeight:    begin top = 4096; field_max = 8191; modest = 3; end
      CfgInWidth:     begin top = 4096; field_max = 8191; modest = 3; end
      CfgBatchCount:  begin top = 256;  field_max = 511;  modest = 2; end
      CfgElemBytes:   begin top = 8;    field_max = 15;   modest = 8; end
      default:        return CfgDataW'($urandom_range(1));
    endcase
    if (roll < 6) return CfgDataW'(top);
    if (roll < 12) begin
      return $urandom_range(1) ? '0 : CfgDataW'($urandom_range(field_max, top + 1));
    end
    return CfgDataW'($urandom_range(modest, 1));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values give a two by two block over a single element: a walk of
  // four, with last on the fourth and a wrap back to element zero.
  task automatic test_default_walk();
    set_idling(0, 0);
    offer_request(1'b1);
    repeat (5) offer_request(1'b0);
    wait_idle();
  endtask

  // Largest legal shape, then values beyond every maximum, then all zeros,
  // which saturate to one so that every element is flagged last.
  task automatic test_register_extremes();
    set_all_regs(16, 4096, 4096, 4096, 256, ModeCrd, 8);
    offer_request(1'b1);
    repeat (2) offer_request(1'b0);
    wait_idle();
    set_all_regs(31, 8191, 8191, 8191, 511, ModeDcr, 15);
    repeat (2) offer_request(1'b0);
    wait_idle();
    set_all_regs(0, 0, 0, 0, 0, ModeCrd, 0);
    offer_request(1'b0);
    offer_request(1'b1);
    wait_idle();
  endtask

  // A small shape moves the batch and channel counters forward quickly. The
  // largest shape is then loaded mid-walk, so that both offsets overflow
  // and wrap. Finally the shape shrinks below the counters' positions.
  task automatic test_offset_wrap();
    set_all_regs(1, 2, 1, 1, 256, ModeDcr, 1);
    offer_request(1'b1);
    repeat (6) offer_request(1'b0);
    wait_idle();
    set_all_regs(16, 4096, 4096, 4096, 256, ModeCrd, 8);
    repeat (3) offer_request(1'b0);
    wait_idle();
    set_all_regs(2, 1, 1, 1, 1, ModeDcr, 3);
    repeat (3) offer_request(1'b0);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and the block must stall its input.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    set_all_regs(2, 2, 2, 3, 2, ModeCrd, 4);
    -> hold_start;
    offer_request(1'b1);
    repeat (39) offer_request(1'b0);
    wait_idle();
  endtask

  // Random phases, each with a fresh set of registers, some of them left
  // untouched so that the walk carries on from its old position. Idling
  // patterns rotate: none, sender idle, receiver stalling, both.
  task automatic test_random_walks();
    int unsigned items;
    bit [6:0]    sel;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph % 4)
        0:       set_idling(0, 0);
        1:       set_idling(58, 0);
        2:       set_idling(0, 58);
        default: set_idling(21, 21);
      endcase
      for (int i = 0; i < 7; i++) reg_plan[i] = pick_value(d2s_cfg_e'(i));
      sel = $urandom_range(1) ? 7'h7F : 7'($urandom());
      apply_plan(sel);
      items = $urandom_range(35, 15);
      for (int k = 0; k < items; k++) offer_request($urandom_range(99) < 6);
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    rst_ni        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_walk();
    test_register_extremes();
    test_offset_wrap();
    test_output_backpressure();
    test_random_walks();

    if (fail_count == 0) begin
      $display("depth_to_space_address_gen_top regression: pass");
    end else begin
      $display("depth_to_space_address_gen_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/d2s_pkg.sv
hw/rtl/d2s_in_if.sv
hw/rtl/d2s_out_if.sv
hw/rtl/d2s_ctrl.sv
hw/rtl/d2s_dpath.sv
hw/rtl/depth_to_space_address_gen_top.sv
tb/tb_depth_to_space_address_gen_top.sv
